// ===== hw/rtl/sfcu_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcu_pkg
// Shared types and constants for the safety fault collection unit.
// ----------------------------------------------------------------------------
package sfcu_pkg;

    localparam int ItemCount = 64;
    localparam int ItemW     = 6;

    localparam logic [7:0] FailMax   = 8'hFF;
    localparam logic [7:0] CfgSilent = 8'd1;
    localparam logic [7:0] CfgReset  = 8'd2;
    localparam logic [1:0] PassLimit = 2'd2;

    localparam logic [1:0] REQ_FAIL = 2'd0;
    localparam logic [1:0] REQ_PASS = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_NOP  = 2'd3;

    localparam logic [2:0] CLS_RESET   = 3'd1;
    localparam logic [2:0] CLS_COUNTED = 3'd2;
    localparam logic [2:0] CLS_RXSAT   = 3'd3;
    localparam logic [2:0] CLS_CFG     = 3'd4;

    localparam logic [2:0] REG_PLANE0  = 3'd0;
    localparam logic [2:0] REG_PLANE1  = 3'd1;
    localparam logic [2:0] REG_PLANE2  = 3'd2;
    localparam logic [2:0] REG_SILENT  = 3'd3;
    localparam logic [2:0] REG_RESET   = 3'd4;
    localparam logic [2:0] REG_TICK0   = 3'd5;
    localparam logic [2:0] REG_TICK1   = 3'd6;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] item;
    } sfcu_in_t;

    typedef struct packed {
        logic        reset_request;
        logic        silent_on;
        logic [63:0] fault_mask;
        logic [63:0] status_mask;
        logic [63:0] history_mask;
        logic [31:0] sample_count;
        logic [7:0]  item_fail_count;
    } sfcu_out_t;

    // Command word handed from front to back.
    typedef struct packed {
        logic [1:0]       req_type;
        logic [ItemW-1:0] item;
    } sfcu_cmd_t;

endpackage

// ===== hw/rtl/sfcu_front.sv =====
// ----------------------------------------------------------------------------
// sfcu_front
// Input stage plus a two-entry command queue toward the execution stage.
// ----------------------------------------------------------------------------
module sfcu_front
    import sfcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sfcu_in_t  in_data,
    output logic      cmd_valid,
    input  logic      cmd_ready,
    output sfcu_cmd_t cmd
);

    sfcu_cmd_t  q_reg [2];
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        rd_next  = pop  ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= '{req_type: in_data.req_type, item: in_data.item};
        end
    end

endmodule

// ===== hw/rtl/sfcu_back.sv =====
// ----------------------------------------------------------------------------
// sfcu_back
// Execution stage: updates counts and masks, holds the result register.
// ----------------------------------------------------------------------------
module sfcu_back
    import sfcu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  sfcu_cmd_t   cmd,
    input  logic [63:0] plane0,
    input  logic [63:0] plane1,
    input  logic [63:0] plane2,
    input  logic [7:0]  silent_lvl,
    input  logic [7:0]  reset_lvl,
    input  logic [5:0]  tick0,
    input  logic [5:0]  tick1,
    output logic        out_valid,
    input  logic        out_ready,
    output sfcu_out_t   out_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_UPD0 = 6'b000010,
        ST_RD1  = 6'b000100,
        ST_UPD1 = 6'b001000,
        ST_RD2  = 6'b010000,
        ST_DONE = 6'b100000
    } back_state_t;

    // Per-item {pass count, fail count}; an entry reads as zero until written.
    logic [9:0]           cnt_mem [ItemCount];
    logic [9:0]           rd_data_reg;
    logic                 rd_vld_reg;
    logic [ItemCount-1:0] vld_reg, vld_next;
    logic [ItemW-1:0]     rd_addr, upd_item;
    logic                 wr_en;
    logic [9:0]           wr_data, cur_ent;
    back_state_t          state_reg, state_next;
    sfcu_cmd_t            cmd_reg;
    logic [63:0] status_reg, status_next, fault_reg, fault_next, hist_reg, hist_next;
    logic [31:0] ticks_reg, ticks_next;
    logic        latched_reg, latched_next;
    logic [7:0]  depth_reg, depth_next;
    logic        silent_reg, silent_next;
    logic        ov_reg;
    sfcu_out_t   out_reg;
    logic        fire, pulse, load_out;
    logic [7:0]  out_cnt;

    assign cmd_ready = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign fire      = cmd_valid && cmd_ready;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign cur_ent   = rd_vld_reg ? rd_data_reg : 10'd0;
    assign upd_item  = (state_reg == ST_UPD1) ? tick1 :
                       (cmd_reg.req_type == REQ_TICK) ? tick0 : cmd_reg.item;

    function automatic logic [2:0] cls_of(input logic [5:0] i, input logic [63:0] p0,
                                          input logic [63:0] p1, input logic [63:0] p2);
        cls_of = {p2[i], p1[i], p0[i]};
    endfunction

    // Pass update of one entry: returns {silent depth drop, new entry}.
    function automatic logic [10:0] pass_upd(input logic [2:0] cls, input logic [9:0] ent,
                                             input logic [7:0] slvl);
        logic [1:0] pc;
        logic [9:0] res;
        logic       dec;
        pc  = ent[9:8];
        res = ent;
        dec = 1'b0;
        if (cls == CLS_COUNTED || cls == CLS_RXSAT)
        begin
            pc  = ent[9:8] + 2'd1;
            res = {pc, ent[7:0]};
            if (pc >= PassLimit)
            begin
                dec = (cls == CLS_COUNTED) && (ent[7:0] >= slvl);
                res = 10'd0;
            end
        end
        pass_upd = {dec, res};
    endfunction

    always_comb
    begin
        logic [2:0]  cls;
        logic [7:0]  fc, sl, rl;
        logic [10:0] pu;
        logic        do_fail, do_pass;
        state_next   = state_reg;
        vld_next     = vld_reg;
        status_next  = status_reg;
        fault_next   = fault_reg;
        hist_next    = hist_reg;
        ticks_next   = ticks_reg;
        latched_next = latched_reg;
        depth_next   = depth_reg;
        silent_next  = silent_reg;
        rd_addr      = cmd_reg.item;
        wr_en        = 1'b0;
        wr_data      = cur_ent;
        load_out     = 1'b0;
        pulse        = 1'b0;
        out_cnt      = cur_ent[7:0];
        do_fail      = 1'b0;
        do_pass      = 1'b0;
        cls          = cls_of(upd_item, plane0, plane1, plane2);
        fc           = 8'd0;
        sl           = 8'd0;
        rl           = 8'd0;
        pu           = 11'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // Start reading the first item while the command is taken.
                rd_addr = (cmd.req_type == REQ_TICK) ? tick0 : cmd.item;
                if (fire)
                begin
                    state_next = ST_UPD0;
                end
            end
            ST_UPD0:
            begin
                unique case (cmd_reg.req_type)
                    REQ_FAIL:
                    begin
                        do_fail    = 1'b1;
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    REQ_PASS:
                    begin
                        do_pass    = 1'b1;
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    REQ_TICK:
                    begin
                        ticks_next = ticks_reg + 32'd1;
                        do_pass    = 1'b1;
                        state_next = ST_RD1;
                    end
                    REQ_NOP:
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD1:
            begin
                // Read the second tick item after the first one is written.
                rd_addr    = tick1;
                state_next = ST_UPD1;
            end
            ST_UPD1:
            begin
                do_pass    = 1'b1;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                rd_addr    = cmd_reg.item;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_fail)
        begin
            status_next[upd_item] = 1'b1;
            hist_next[upd_item]   = 1'b1;
            fc = (cur_ent[7:0] < FailMax) ? cur_ent[7:0] + 8'd1 : cur_ent[7:0];
            wr_en   = 1'b1;
            wr_data = {2'd0, fc};
            vld_next[upd_item] = 1'b1;
            out_cnt = fc;
            sl = (cls == CLS_CFG) ? CfgSilent : silent_lvl;
            rl = (cls == CLS_CFG) ? CfgReset  : reset_lvl;
            if (cls == CLS_RESET || ((cls == CLS_COUNTED || cls == CLS_CFG) && fc >= rl))
            begin
                if (!latched_reg)
                begin
                    fault_next[upd_item] = 1'b1;
                    latched_next         = 1'b1;
                    pulse                = 1'b1;
                end
            end
            else if ((cls == CLS_COUNTED || cls == CLS_CFG) && fc == sl)
            begin
                fault_next[upd_item] = 1'b1;
                depth_next           = depth_reg + 8'd1;
                silent_next          = 1'b1;
            end
        end

        if (do_pass)
        begin
            pu      = pass_upd(cls, cur_ent, silent_lvl);
            wr_en   = 1'b1;
            wr_data = pu[9:0];
            vld_next[upd_item] = 1'b1;
            out_cnt = pu[7:0];
            if (pu[10])
            begin
                depth_next = depth_reg - 8'd1;
                if (depth_next == 8'd0)
                begin
                    silent_next = 1'b0;
                end
            end
            if (pu[7:0] == 8'd0)
            begin
                status_next[upd_item] = 1'b0;
                fault_next[upd_item]  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmd_reg     <= '0;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            status_reg  <= '0;
            fault_reg   <= '0;
            hist_reg    <= '0;
            ticks_reg   <= '0;
            latched_reg <= 1'b0;
            depth_reg   <= '0;
            silent_reg  <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (fire)
            begin
                cmd_reg <= cmd;
            end
            vld_reg     <= vld_next;
            rd_vld_reg  <= vld_reg[rd_addr];
            status_reg  <= status_next;
            fault_reg   <= fault_next;
            hist_reg    <= hist_next;
            ticks_reg   <= ticks_next;
            latched_reg <= latched_next;
            depth_reg   <= depth_next;
            silent_reg  <= silent_next;
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[upd_item] <= wr_data;
        end
        rd_data_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= '{reset_request:   pulse,
                         silent_on:       silent_next,
                         fault_mask:      fault_next,
                         status_mask:     status_next,
                         history_mask:    hist_next,
                         sample_count:    ticks_next,
                         item_fail_count: out_cnt};
        end
    end

endmodule

// ===== hw/rtl/safety_fault_collection_unit.sv =====
// ----------------------------------------------------------------------------
// safety_fault_collection_unit
// Fault collector for 64 monitored items with class-based reactions.
// ----------------------------------------------------------------------------
// Path: a fail, pass or idle word goes through the queue, then the idle and
//   update states of the execution stage, then the result register; a sample
//   tick also reads and writes both tick items and then reads the addressed item.
// Flow: the execution stage takes no new word until it has finished the current
//   one; a result word that is not taken holds it.
// Reset: rst_n clears masks and the queue and resets the config registers at once;
//   the count store keeps its contents, but a per-item valid flag reads it as zero.
module safety_fault_collection_unit
    import sfcu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sfcu_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output sfcu_out_t   out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    // Configuration registers.
    logic [63:0] plane0_reg, plane1_reg, plane2_reg;
    logic [7:0]  silent_lvl_reg, reset_lvl_reg;
    logic [5:0]  tick0_reg, tick1_reg;

    // Front-to-back command word.
    logic      cmd_valid, cmd_ready;
    sfcu_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane0_reg     <= '0;
            plane1_reg     <= '0;
            plane2_reg     <= '0;
            silent_lvl_reg <= 8'd3;
            reset_lvl_reg  <= 8'd20;
            tick0_reg      <= 6'd0;
            tick1_reg      <= 6'd1;
        end
        else if (cfg_we)
        begin
            // Decode the register index; unused indexes drop the write.
            unique case (cfg_index)
                REG_PLANE0: plane0_reg     <= cfg_wdata;
                REG_PLANE1: plane1_reg     <= cfg_wdata;
                REG_PLANE2: plane2_reg     <= cfg_wdata;
                REG_SILENT: silent_lvl_reg <= cfg_wdata[7:0];
                REG_RESET:  reset_lvl_reg  <= cfg_wdata[7:0];
                REG_TICK0:  tick0_reg      <= cfg_wdata[5:0];
                REG_TICK1:  tick1_reg      <= cfg_wdata[5:0];
                default:    ;
            endcase
        end
    end

    // Accept and queue incoming words.
    sfcu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Execute updates and hold the result word.
    sfcu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .plane0     (plane0_reg),
        .plane1     (plane1_reg),
        .plane2     (plane2_reg),
        .silent_lvl (silent_lvl_reg),
        .reset_lvl  (reset_lvl_reg),
        .tick0      (tick0_reg),
        .tick1      (tick1_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ===== test/sfcu_checker.sv =====
// ----------------------------------------------------------------------------
// sfcu_checker
// Watches the request and result channels of the fault collector, keeps its
// own model of the per-item counts and masks, and compares every result word
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sfcu_checker
    import sfcu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  sfcu_in_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  sfcu_out_t   out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] plane0, plane1, plane2;
    logic [7:0]  silent_lvl, reset_lvl;
    logic [5:0]  tick_a, tick_b;
    logic [7:0]  fails [ItemCount];
    logic [1:0]  passes [ItemCount];
    logic [63:0] status_m, fault_m, history_m;
    logic [31:0] ticks;
    logic        rst_latched;
    logic [7:0]  depth;
    logic        silent;
    sfcu_out_t   expected_words [$];

    assign pending = expected_words.size();

    function automatic logic [2:0] class_of(int i);
        return {plane2[i], plane1[i], plane0[i]};
    endfunction

    function automatic logic latch_reset(int i);
        if (rst_latched)
            return 1'b0;
        fault_m[i]  = 1'b1;
        rst_latched = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic escalate(int i, logic [7:0] s_lvl, logic [7:0] r_lvl);
        if (fails[i] >= r_lvl)
            return latch_reset(i);
        if (fails[i] == s_lvl)
        begin
            fault_m[i] = 1'b1;
            depth      = depth + 8'd1;
            silent     = 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic record_fail(int i);
        status_m[i]  = 1'b1;
        history_m[i] = 1'b1;
        if (fails[i] < FailMax)
            fails[i] = fails[i] + 8'd1;
        passes[i] = 2'd0;
        case (class_of(i))
            CLS_RESET:   return latch_reset(i);
            CLS_COUNTED: return escalate(i, silent_lvl, reset_lvl);
            CLS_CFG:     return escalate(i, CfgSilent, CfgReset);
            default:     return 1'b0;
        endcase
    endfunction

    function automatic void record_pass(int i);
        logic [2:0] cls;
        cls = class_of(i);
        if (cls == CLS_COUNTED || cls == CLS_RXSAT)
        begin
            passes[i] = passes[i] + 2'd1;
            if (passes[i] >= PassLimit)
            begin
                if (cls == CLS_COUNTED && fails[i] >= silent_lvl)
                begin
                    depth = depth - 8'd1;
                    if (depth == 8'd0)
                        silent = 1'b0;
                end
                fails[i]  = 8'd0;
                passes[i] = 2'd0;
            end
        end
        if (fails[i] == 8'd0)
        begin
            status_m[i] = 1'b0;
            fault_m[i]  = 1'b0;
        end
    endfunction

    function automatic sfcu_out_t collect_fault(sfcu_in_t w);
        sfcu_out_t r;
        r = '0;
        case (w.req_type)
            REQ_FAIL: r.reset_request = record_fail(w.item);
            REQ_PASS: record_pass(w.item);
            REQ_TICK:
            begin
                ticks = ticks + 32'd1;
                record_pass(tick_a);
                record_pass(tick_b);
            end
            default: ;
        endcase
        r.silent_on       = silent;
        r.fault_mask      = fault_m;
        r.status_mask     = status_m;
        r.history_mask    = history_m;
        r.sample_count    = ticks;
        r.item_fail_count = fails[w.item];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfcu_out_t e;
        if (!rst_n)
        begin
            plane0 = '0; plane1 = '0; plane2 = '0;
            silent_lvl = 8'd3; reset_lvl = 8'd20;
            tick_a = 6'd0; tick_b = 6'd1;
            for (int i = 0; i < ItemCount; i++)
            begin
                fails[i]  = '0;
                passes[i] = '0;
            end
            status_m = '0; fault_m = '0; history_m = '0;
            ticks = '0; rst_latched = 1'b0; depth = '0; silent = 1'b0;
            expected_words.delete();
            fail_count = 0;
        end
        else
        begin
            // Compare the result first: a prediction is never due in its own cycle.
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, out_data);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e.reset_request !== out_data.reset_request ||
                        e.silent_on !== out_data.silent_on ||
                        e.fault_mask !== out_data.fault_mask ||
                        e.status_mask !== out_data.status_mask ||
                        e.history_mask !== out_data.history_mask ||
                        e.sample_count !== out_data.sample_count ||
                        e.item_fail_count !== out_data.item_fail_count)
                    begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, e, out_data);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (cfg_we)
                case (cfg_index)
                    REG_PLANE0: plane0 = cfg_wdata;
                    REG_PLANE1: plane1 = cfg_wdata;
                    REG_PLANE2: plane2 = cfg_wdata;
                    REG_SILENT: silent_lvl = cfg_wdata[7:0];
                    REG_RESET:  reset_lvl = cfg_wdata[7:0];
                    REG_TICK0:  tick_a = cfg_wdata[5:0];
                    REG_TICK1:  tick_b = cfg_wdata[5:0];
                    default: ;
                endcase
            if (in_valid && in_ready)
                expected_words.push_back(collect_fault(in_data));
        end
    end
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives fail reports, pass reports and sample ticks into the fault collector
// under several class tables and threshold settings, with random gaps on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import sfcu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    sfcu_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    sfcu_out_t   out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    int          fail_count;
    int          pending;
    bit          stall_free;

    safety_fault_collection_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sfcu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap length: mostly zero or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: drop ready for random stretches, hold it in quiet windows.
    initial
    begin
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            int g;
            g = stall_free ? 0 : gap_len();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    // Send one request word; valid holds until accepted and stays up for a
    // following word with no gap.
    task automatic send_word(logic [1:0] req, logic [5:0] idx);
        int g;
        g = stall_free ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{req_type: req, item: idx};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every predicted word has come back, plus pipeline slack.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random request, biased toward fails and passes on a small item set so
    // counts climb through the silent and reset thresholds.
    task automatic random_word(logic [5:0] hot);
        int r;
        logic [5:0] idx;
        r   = $urandom_range(0, 99);
        idx = ($urandom_range(0, 3) != 0) ? hot + 6'($urandom_range(0, 3))
                                          : 6'($urandom);
        if (r < 50)      send_word(REQ_FAIL, idx);
        else if (r < 80) send_word(REQ_PASS, idx);
        else if (r < 97) send_word(REQ_TICK, 6'($urandom));
        else             send_word(REQ_NOP, idx);
    endtask

    initial
    begin
        logic [5:0] hot;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_PLANE0;
        cfg_wdata = '0;
        stall_free = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: default table (all none), then every class on a few items.
        send_word(REQ_FAIL, 6'd0);
        send_word(REQ_FAIL, 6'd63);
        send_word(REQ_PASS, 6'd63);
        send_word(REQ_TICK, 6'd63);
        send_word(REQ_NOP, 6'd5);
        drain();
        // item 1 reset class, 2 counted, 3 rxsat, 4 cfg, 63 rxsat
        write_reg(REG_PLANE0, 64'h8000_0000_0000_000A);
        write_reg(REG_PLANE1, 64'h8000_0000_0000_000C);
        write_reg(REG_PLANE2, 64'h0000_0000_0000_0010);
        write_reg(REG_SILENT, 64'd2);
        write_reg(REG_RESET, 64'd4);
        write_reg(REG_TICK0, 64'd2);
        write_reg(REG_TICK1, 64'd2);
        send_word(REQ_FAIL, 6'd1);
        send_word(REQ_FAIL, 6'd4);
        send_word(REQ_FAIL, 6'd4);
        repeat (5) send_word(REQ_FAIL, 6'd2);
        send_word(REQ_FAIL, 6'd3);
        send_word(REQ_PASS, 6'd3);
        send_word(REQ_PASS, 6'd3);
        send_word(REQ_TICK, 6'd0);
        send_word(REQ_FAIL, 6'd63);
        send_word(REQ_FAIL, 6'd63);
        send_word(REQ_PASS, 6'd63);
        send_word(REQ_PASS, 6'd63);
        send_word(REQ_TICK, 6'd0);

        // Hold the sender until the block is fully drained once.
        drain();

        // Random phases across threshold extremes and random class tables.
        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            write_reg(REG_PLANE0, rand64());
            write_reg(REG_PLANE1, rand64());
            write_reg(REG_PLANE2, rand64());
            case (ph)
                0: begin write_reg(REG_SILENT, 64'd0);   write_reg(REG_RESET, 64'd0);   end
                1: begin write_reg(REG_SILENT, 64'd255); write_reg(REG_RESET, 64'd255); end
                2: begin write_reg(REG_SILENT, 64'd1);   write_reg(REG_RESET, 64'd255); end
                default:
                begin
                    write_reg(REG_SILENT, 64'($urandom_range(0, 6)));
                    write_reg(REG_RESET, 64'($urandom_range(2, 12)));
                end
            endcase
            write_reg(REG_TICK0, 64'($urandom_range(0, 63)));
            write_reg(REG_TICK1, (ph == 4) ? 64'd63 : 64'($urandom_range(0, 63)));
            stall_free = (ph == 5);
            hot = 6'($urandom);
            for (int n = 0; n < 120; n++)
            begin
                if ($urandom_range(0, 29) == 0) hot = 6'($urandom);
                random_word(hot);
            end
        end
        // Fail count saturation: hammer one item past 255.
        drain();
        write_reg(REG_PLANE2, 64'd0);
        repeat (260) send_word(REQ_FAIL, 6'd40);
        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/sfcu_pkg.sv
hw/rtl/sfcu_front.sv
hw/rtl/sfcu_back.sv
hw/rtl/safety_fault_collection_unit.sv
test/sfcu_checker.sv
test/tb_top.sv
